@@ rtl/core/pure_pursuit_steering_macros.svh @@
// Assertion macros shared by the steering checker.
// Needs a clock named clk and a reset named rst in the using scope.
`ifndef PURE_PURSUIT_STEERING_MACROS_SVH
`define PURE_PURSUIT_STEERING_MACROS_SVH

// Same-cycle implication.
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/pps_pkg.sv @@
// Constants shared by the steering block: field widths and fixed limits.
// No dependencies.
package pps_pkg;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int HEAD_W    = 18;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int LA_W      = 21;
  localparam int LIN_W     = 19;
  localparam int ANG_W     = 20;
  localparam int OUT_ANG_W = 21;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 21;
  localparam int SQ_W      = 2 * LA_W;
  localparam int ROT_W     = HEAD_W + DIFF_W + 1;
  localparam int MAG_W     = 31;
  localparam int LEN2_W    = 2 * MAG_W + 1;
  localparam logic [MAG_W-1:0] CURV_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_LOOK_AHEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANG    = 2'd2;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;
endpackage

@@ rtl/core/pps_path_mem.sv @@
// Path point store: one write port, one registered read port.
// Uses pps_pkg for the coordinate width.
module pps_path_mem import pps_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [COORD_W-1:0] wr_x,
  input  logic [COORD_W-1:0] wr_y,
  input  logic [AW-1:0]      rd_addr,
  output logic [COORD_W-1:0] rd_x,
  output logic [COORD_W-1:0] rd_y
);
  logic [COORD_W-1:0] mem_x [DEPTH];
  logic [COORD_W-1:0] mem_y [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end
endmodule

@@ rtl/core/pps_mul.sv @@
// Shared signed multiplier used by every product of the sequencer.
// Uses pps_pkg for operand widths.
module pps_mul import pps_pkg::*; (
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod
);
  assign prod = PROD_W'(op_a) * PROD_W'(op_b);
endmodule

@@ rtl/core/pps_div.sv @@
// Bit-serial restoring divider for the curvature quotient, saturating.
// Uses pps_pkg for magnitude widths and the curvature limit.
module pps_div import pps_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int S_W       = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  num_b,
  input  logic [LEN2_W-1:0] den,
  input  logic [S_W-1:0]    shift,
  output logic              busy,
  output logic [MAG_W-1:0]  kmag
);
  localparam int NUM_W = MAG_W + 1 + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num;
  logic [LEN2_W-1:0] rem;
  logic [LEN2_W-1:0] dv;
  logic [MAG_W:0]    q;
  logic              sat;
  logic [CNT_W-1:0]  cnt;
  logic [S_W-1:0]    sh;
  logic [LEN2_W:0]   rem_sh;
  logic              ge;
  logic [MAG_W:0]    q_next;

  always_comb begin
    rem_sh = {rem, num[NUM_W-1]};
    ge     = rem_sh >= {1'b0, dv};
    q_next = {q[MAG_W-1:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= NUM_W'({num_b, 1'b0}) << (2 * FRAC_BITS);
      rem <= '0;
      dv  <= den;
      q   <= '0;
      sat <= 1'b0;
      cnt <= CNT_W'(NUM_W);
      sh  <= shift;
    end else if (busy) begin
      num <= {num[NUM_W-2:0], 1'b0};
      rem <= ge ? LEN2_W'(rem_sh - {1'b0, dv}) : rem_sh[LEN2_W-1:0];
      q   <= q_next;
      sat <= sat | q[MAG_W-1];
      cnt <= cnt - CNT_W'(1);
      // last quotient bit: clamp or scale back by the normalising shift
      if (cnt == CNT_W'(1)) begin
        kmag <= (sat | q[MAG_W-1]) ? CURV_MAX : MAG_W'(q_next >> sh);
      end
    end
  end
endmodule

@@ rtl/core/pure_pursuit_steering.sv @@
// Pure pursuit steering top level: path store, sequencer, shared multiplier
// and serial divider. Depends on pps_pkg, pps_path_mem, pps_mul, pps_div.
//
// Usage: drive start with func and the payload; the beat is taken when start
// is high and busy is low. A load beat (func 0) stores one path point, unless
// the path is full, and leaves busy low; first_point restarts the path at
// entry 0. A compute beat (func 1) raises busy while the sequencer squares
// the look-ahead and walks the path from the newest point backwards through
// the shared multiplier, then fetches the carrot, rotates it into the robot
// frame and forms x*x + y*y, runs the curvature division one quotient bit a
// cycle (skipped when the curvature is zero) and scales the turn rate. For an
// empty path this work is skipped and done still rises. The next beat may be
// taken in the cycle that shows done. done is high for exactly one cycle with
// the result on the output ports, which hold it until the next result; the
// receiver takes it then and cannot stall. Configuration writes use
// cfg_valid/cfg_ready (always ready); the user must make them only while
// idle, as the block itself does not enforce this. Reset empties the path and
// loads the register defaults.
module pure_pursuit_steering import pps_pkg::*; #(
  parameter int PATH_DEPTH = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  output logic                        done,
  input  logic                        func,
  input  logic signed [COORD_W-1:0]   pos_x,
  input  logic signed [COORD_W-1:0]   pos_y,
  input  logic signed [HEAD_W-1:0]    heading_cos,
  input  logic signed [HEAD_W-1:0]    heading_sin,
  input  logic                        first_point,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_data,
  output logic                        valid_res,
  output logic [LIN_W-1:0]            linear_speed,
  output logic signed [OUT_ANG_W-1:0] angular_speed,
  output logic signed [COORD_W-1:0]   carrot_x,
  output logic signed [COORD_W-1:0]   carrot_y
);
  localparam int AW    = $clog2(PATH_DEPTH);
  localparam int LEN_W = $clog2(PATH_DEPTH + 1);
  localparam int XR_W  = ROT_W - FRAC_BITS;
  localparam int S_W   = $clog2(XR_W);
  localparam logic [LEN2_W-1:0] CURV_THR =
    LEN2_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd500) / 64'd1000);
  localparam logic signed [ROT_W-1:0] HALF = ROT_W'(1) <<< (FRAC_BITS - 1);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001, S_LA    = 20'h00002, S_SRD   = 20'h00004,
    S_SDIF  = 20'h00008, S_SQX   = 20'h00010, S_SQY   = 20'h00020,
    S_FETCH = 20'h00040, S_LATCH = 20'h00080, S_ROT0  = 20'h00100,
    S_ROT1  = 20'h00200, S_ROT2  = 20'h00400, S_ROT3  = 20'h00800,
    S_ROUND = 20'h01000, S_NORM  = 20'h02000, S_SQA   = 20'h04000,
    S_SQB   = 20'h08000, S_CHK   = 20'h10000, S_DIV   = 20'h20000,
    S_ANG   = 20'h40000, S_EMPTY = 20'h80000
  } state_t;

  state_t state;
  state_t state_next;

  logic [LA_W-1:0]  look_ahead;
  logic [LIN_W-1:0] max_lin;
  logic [ANG_W-1:0] max_ang;
  logic [LEN_W-1:0] path_len;

  logic signed [COORD_W-1:0] px, py;
  logic signed [HEAD_W-1:0]  hc, hs;
  logic [AW-1:0]             cnt;
  logic [SQ_W-1:0]           la2, sqx;
  logic [LA_W-1:0]           ddx, ddy;
  logic                      big;
  logic signed [COORD_W-1:0] cx, cy;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic signed [ROT_W-1:0]   xs, ys;
  logic signed [XR_W-1:0]    xr, yr;
  logic [MAG_W-1:0]          ma, mb;
  logic [S_W-1:0]            shift;
  logic                      yneg, kzero;
  logic [LEN2_W-1:0]         len2;

  logic                      accept, wr_en;
  logic [COORD_W-1:0]        rd_x, rd_y;
  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      div_start, div_busy;
  logic [MAG_W-1:0]          kmag;

  logic signed [DIFF_W-1:0]  diff_x, diff_y;
  logic [DIFF_W-1:0]         mag_x, mag_y;
  logic [SQ_W:0]             dist2;
  logic signed [ROT_W-1:0]   xs_rnd, ys_rnd;
  logic [XR_W-1:0]           ax, ay, am;
  logic [S_W-1:0]            s_calc;
  logic [PROD_W-1:0]         wprod;
  logic [ANG_W-1:0]          wm;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign wr_en     = accept && func == FUNC_LOAD &&
                     (first_point || path_len != LEN_W'(PATH_DEPTH));

  pps_path_mem #(.DEPTH(PATH_DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (first_point ? AW'(0) : path_len[AW-1:0]),
    .wr_x    (pos_x),
    .wr_y    (pos_y),
    .rd_addr (cnt),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  pps_mul u_mul (.op_a(op_a), .op_b(op_b), .prod(prod));

  pps_div #(.FRAC_BITS(FRAC_BITS), .S_W(S_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_b (mb),
    .den   (len2),
    .shift (shift),
    .busy  (div_busy),
    .kmag  (kmag)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_LA:   begin op_a = MUL_W'(look_ahead); op_b = MUL_W'(look_ahead); end
      S_SQX:  begin op_a = MUL_W'(ddx);        op_b = MUL_W'(ddx);        end
      S_SQY:  begin op_a = MUL_W'(ddy);        op_b = MUL_W'(ddy);        end
      S_ROT0: begin op_a = dx;                 op_b = MUL_W'(hc);         end
      S_ROT1: begin op_a = dy;                 op_b = MUL_W'(hs);         end
      S_ROT2: begin op_a = dy;                 op_b = MUL_W'(hc);         end
      S_ROT3: begin op_a = dx;                 op_b = MUL_W'(hs);         end
      S_SQA:  begin op_a = MUL_W'(ma);         op_b = MUL_W'(ma);         end
      S_SQB:  begin op_a = MUL_W'(mb);         op_b = MUL_W'(mb);         end
      S_ANG:  begin op_a = MUL_W'(kmag);       op_b = MUL_W'(max_ang);    end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    diff_x = DIFF_W'(signed'(rd_x)) - DIFF_W'(px);
    diff_y = DIFF_W'(signed'(rd_y)) - DIFF_W'(py);
    mag_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
    mag_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
    dist2  = {1'b0, sqx} + (SQ_W + 1)'(prod[SQ_W-1:0]);
    xs_rnd = (xs + HALF) >>> FRAC_BITS;
    ys_rnd = (ys + HALF) >>> FRAC_BITS;
    ax     = xr[XR_W-1] ? XR_W'(-xr) : XR_W'(xr);
    ay     = yr[XR_W-1] ? XR_W'(-yr) : XR_W'(yr);
    am     = ax | ay;
    s_calc = '0;
    for (int i = MAG_W; i < XR_W; i++) begin
      if (am[i]) s_calc = S_W'(i - MAG_W + 1);
    end
    wprod  = PROD_W'(prod) >> FRAC_BITS;
    wm     = (wprod > PROD_W'(max_ang)) ? max_ang : wprod[ANG_W-1:0];
  end

  assign div_start = (state == S_CHK) &&
                     !(len2 == '0 || (shift == '0 && len2 <= CURV_THR));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && func == FUNC_COMPUTE) begin
          state_next = (path_len == '0) ? S_EMPTY : S_LA;
        end
      end
      S_LA:    state_next = S_SRD;
      S_SRD:   state_next = S_SDIF;
      S_SDIF:  state_next = S_SQX;
      S_SQX:   state_next = S_SQY;
      S_SQY: begin
        if ((!big && dist2 <= {1'b0, la2}) || cnt == '0) state_next = S_FETCH;
        else state_next = S_SRD;
      end
      S_FETCH: state_next = S_LATCH;
      S_LATCH: state_next = S_ROT0;
      S_ROT0:  state_next = S_ROT1;
      S_ROT1:  state_next = S_ROT2;
      S_ROT2:  state_next = S_ROT3;
      S_ROT3:  state_next = S_ROUND;
      S_ROUND: state_next = S_NORM;
      S_NORM:  state_next = S_SQA;
      S_SQA:   state_next = S_SQB;
      S_SQB:   state_next = S_CHK;
      S_CHK:   state_next = div_start ? S_DIV : S_ANG;
      S_DIV:   state_next = div_busy ? S_DIV : S_ANG;
      S_ANG:   state_next = S_IDLE;
      S_EMPTY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      path_len   <= '0;
      look_ahead <= LA_W'(32768);
      max_lin    <= LIN_W'(19661);
      max_ang    <= ANG_W'(65536);
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_ANG) || (state == S_EMPTY);
      if (wr_en) begin
        path_len <= first_point ? LEN_W'(1) : path_len + LEN_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOOK_AHEAD: look_ahead <= cfg_data[LA_W-1:0];
          REG_MAX_LIN:    max_lin    <= cfg_data[LIN_W-1:0];
          REG_MAX_ANG:    max_ang    <= cfg_data[ANG_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        px  <= pos_x;
        py  <= pos_y;
        hc  <= heading_cos;
        hs  <= heading_sin;
        cnt <= AW'(path_len - LEN_W'(1));
      end
      S_LA:   la2 <= prod[SQ_W-1:0];
      S_SDIF: begin
        ddx <= mag_x[LA_W-1:0];
        ddy <= mag_y[LA_W-1:0];
        big <= (mag_x[DIFF_W-1:LA_W] != '0) || (mag_y[DIFF_W-1:LA_W] != '0);
      end
      S_SQX:  sqx <= prod[SQ_W-1:0];
      S_SQY: begin
        // step back one point unless this one is inside the look-ahead or is the oldest
        if (!(!big && dist2 <= {1'b0, la2}) && cnt != '0) cnt <= cnt - AW'(1);
        else if (big || dist2 > {1'b0, la2}) cnt <= '0;
      end
      S_LATCH: begin
        cx <= rd_x;
        cy <= rd_y;
        dx <= diff_x;
        dy <= diff_y;
      end
      S_ROT0:  xs <= ROT_W'(prod);
      S_ROT1:  xs <= xs + ROT_W'(prod);
      S_ROT2:  ys <= ROT_W'(prod);
      S_ROT3:  ys <= ys - ROT_W'(prod);
      S_ROUND: begin
        xr <= XR_W'(xs_rnd);
        yr <= XR_W'(ys_rnd);
      end
      S_NORM: begin
        ma    <= MAG_W'(ax >> s_calc);
        mb    <= MAG_W'(ay >> s_calc);
        shift <= s_calc;
        yneg  <= yr[XR_W-1];
      end
      S_SQA:  len2 <= LEN2_W'(prod);
      S_SQB:  len2 <= len2 + LEN2_W'(prod);
      S_CHK:  kzero <= !div_start;
      S_ANG: begin
        valid_res     <= 1'b1;
        linear_speed  <= max_lin;
        carrot_x      <= cx;
        carrot_y      <= cy;
        if (kzero) angular_speed <= '0;
        else if (yneg) angular_speed <= -OUT_ANG_W'(wm);
        else angular_speed <= OUT_ANG_W'(wm);
      end
      S_EMPTY: begin
        valid_res     <= 1'b0;
        linear_speed  <= '0;
        angular_speed <= '0;
        carrot_x      <= '0;
        carrot_y      <= '0;
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/core/pps_checker.sv @@
// Port-level checker for the steering block, bound to the top level.
// Depends on pps_pkg and pure_pursuit_steering_macros.svh.
`include "pure_pursuit_steering_macros.svh"
module pps_checker import pps_pkg::*; (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        func,
  input logic                        valid_res,
  input logic [LIN_W-1:0]            linear_speed,
  input logic signed [OUT_ANG_W-1:0] angular_speed
);
  `PPS_ASSERT_NEXT(a_compute_busy, start && !busy && func == FUNC_COMPUTE, busy, "compute beat did not raise busy")
  `PPS_ASSERT_NEXT(a_load_idle, start && !busy && func == FUNC_LOAD, !busy && !done, "load beat made work")
  `PPS_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
  `PPS_ASSERT_NOW(a_empty_zero, done && !valid_res, linear_speed == '0 && angular_speed == '0, "invalid result with speed")
endmodule

bind pure_pursuit_steering pps_checker u_pps_checker (.*);
